// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the lamp sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lsps_pkg
// Types, codes and constants of the lamp state pulse sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsps_pkg;

  localparam int NUM_STATES       = 8;
  localparam int SETTLE_TICKS_DEF = 10;
  localparam int ON_CODE_DEF      = 1;

  localparam int STATE_W    = 3;
  localparam int REQ_W      = 3;
  localparam int OPT_W      = 8;
  localparam int TIMER_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [REQ_W-1:0]      req_type_t;
  typedef logic [OPT_W-1:0]      option_t;
  typedef logic [STATE_W-1:0]    lamp_state_t;
  typedef logic [TIMER_W-1:0]    timer_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam req_type_t REQ_TICK  = 3'd0;
  localparam req_type_t REQ_POWER = 3'd1;
  localparam req_type_t REQ_STATE = 3'd2;
  localparam req_type_t REQ_LIGHT = 3'd3;

  localparam cfg_addr_t CFG_PULSE_WIDTH = 3'd0;
  localparam cfg_addr_t CFG_PULSE_GAP   = 3'd1;
  localparam cfg_addr_t CFG_TRIG_INV    = 3'd2;
  localparam cfg_addr_t CFG_POWER_INV   = 3'd3;
  localparam cfg_addr_t CFG_LIGHT_INV   = 3'd4;

  localparam timer_t PULSE_WIDTH_RST = 16'd50;
  localparam timer_t PULSE_GAP_RST   = 16'd100;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SAME    = 3'd1,
    ST_INVALID = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_PULSE  = 4'b0010,
    PH_GAP    = 4'b0100,
    PH_SETTLE = 4'b1000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic        trigger_pin;
    logic        power_pin;
    logic        light_pin;
    lamp_state_t lamp_state;
    logic        busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/lsps_in_if.sv =====
// ----------------------------------------------------------------------------
// lsps_in_if
// Command channel: valid/ready handshake with request type and option.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsps_in_if;
  import lsps_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  option_t   option;

  modport source (output valid, output req_type, output option, input ready);
  modport sink   (input valid, input req_type, input option, output ready);
endinterface

`default_nettype wire

// ===== rtl/lsps_out_if.sv =====
// ----------------------------------------------------------------------------
// lsps_out_if
// Result channel: valid/ready handshake with status and pin levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lsps_out_if;
  import lsps_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic        trigger_pin;
  logic        power_pin;
  logic        light_pin;
  lamp_state_t lamp_state;
  logic        busy_res;

  modport source (output valid, output status, output trigger_pin, output power_pin,
                  output light_pin, output lamp_state, output busy_res, input ready);
  modport sink   (input valid, input status, input trigger_pin, input power_pin,
                  input light_pin, input lamp_state, input busy_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/lamp_state_pulse_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// lamp_state_pulse_sequencer_unit
// Lamp trigger/power/light sequencer driven by commands and millisecond ticks.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_if.ready is high and answers each with
// one result from the result register; a stalled result side delays it
// further. The command decode and the phase/timer update are a single
// combinational pass from the stored sequencer state into a result register;
// a two-entry result buffer (head plus skid) lets a new item in while an
// earlier result still waits, so in_if.ready drops only when both entries are
// full. Configuration writes take effect on the next edge. After reset the
// block reports busy until SETTLE_TICKS tick items have been seen.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lamp_state_pulse_sequencer_unit #(
  parameter int SETTLE_TICKS = lsps_pkg::SETTLE_TICKS_DEF,
  parameter int ON_CODE      = lsps_pkg::ON_CODE_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  lsps_in_if.sink             in_if,
  lsps_out_if.source          out_if,
  input  wire                 cfg_we,
  input  lsps_pkg::cfg_addr_t cfg_addr,
  input  lsps_pkg::cfg_data_t cfg_wdata
);
  import lsps_pkg::*;

  localparam timer_t      SETTLE_T = TIMER_W'(SETTLE_TICKS);
  localparam option_t     ON_OPT   = OPT_W'(ON_CODE);
  localparam lamp_state_t LAST_ST  = STATE_W'(NUM_STATES - 1);

  timer_t      width_r, gap_r;
  logic        trig_inv_r, power_inv_r, light_inv_r;

  lamp_state_t ind_r, ind_nxt;
  lamp_state_t pulses_r, pulses_nxt;
  phase_t      phase_r, phase_nxt;
  timer_t      timer_r, timer_nxt;
  logic        power_r, power_nxt;
  logic        light_r, light_nxt;

  result_t     res_nxt, head_r, skid_r;
  logic        head_v_r, skid_v_r;
  status_t     status_nxt;

  logic        push, pop;
  lamp_state_t ind_inc, pulses_dec, opt_st, diff;
  logic [STATE_W:0] diff_ext;
  phase_t      settle_ph;

  assign push = in_if.valid && in_if.ready;
  assign pop  = head_v_r && out_if.ready;
  assign in_if.ready = !skid_v_r;

  assign ind_inc    = (ind_r == LAST_ST) ? '0 : ind_r + 1'b1;
  assign pulses_dec = (pulses_r != '0) ? pulses_r - 1'b1 : '0;
  assign opt_st     = in_if.option[STATE_W-1:0];
  assign diff_ext   = (opt_st >= ind_r) ? {1'b0, opt_st} - {1'b0, ind_r}
                    : {1'b0, opt_st} + (STATE_W+1)'(NUM_STATES) - {1'b0, ind_r};
  assign diff       = diff_ext[STATE_W-1:0];
  assign settle_ph  = (SETTLE_T == '0) ? PH_IDLE : PH_SETTLE;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= PULSE_WIDTH_RST;
      gap_r       <= PULSE_GAP_RST;
      trig_inv_r  <= 1'b0;
      power_inv_r <= 1'b0;
      light_inv_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PULSE_WIDTH: width_r     <= cfg_wdata;
        CFG_PULSE_GAP:   gap_r       <= cfg_wdata;
        CFG_TRIG_INV:    trig_inv_r  <= cfg_wdata[0];
        CFG_POWER_INV:   power_inv_r <= cfg_wdata[0];
        CFG_LIGHT_INV:   light_inv_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item processing
  always_comb begin
    ind_nxt    = ind_r;
    pulses_nxt = pulses_r;
    phase_nxt  = phase_r;
    timer_nxt  = timer_r;
    power_nxt  = power_r;
    light_nxt  = light_r;
    status_nxt = ST_OK;
    if (push) begin
      case (in_if.req_type) inside
        REQ_TICK: begin
          unique case (phase_r)
            PH_PULSE: begin
              if (timer_r > 16'd1) begin
                timer_nxt = timer_r - 1'b1;
              end else begin
                ind_nxt    = ind_inc;
                pulses_nxt = pulses_dec;
                if (pulses_dec == '0) begin
                  phase_nxt = PH_IDLE;
                  timer_nxt = '0;
                end else if (gap_r == '0) begin
                  phase_nxt = PH_PULSE;
                  timer_nxt = width_r;
                end else begin
                  phase_nxt = PH_GAP;
                  timer_nxt = gap_r;
                end
              end
            end
            PH_GAP: begin
              if (timer_r > 16'd1) begin
                timer_nxt = timer_r - 1'b1;
              end else begin
                phase_nxt = PH_PULSE;
                timer_nxt = width_r;
              end
            end
            PH_SETTLE: begin
              if (timer_r > 16'd1) begin
                timer_nxt = timer_r - 1'b1;
              end else begin
                phase_nxt = PH_IDLE;
                timer_nxt = '0;
              end
            end
            PH_IDLE: ;
            default: ;
          endcase
        end
        REQ_POWER, REQ_STATE, REQ_LIGHT: begin
          if (phase_r != PH_IDLE) begin
            status_nxt = ST_BUSY;
          end else if (in_if.req_type == REQ_POWER) begin
            power_nxt = (in_if.option == ON_OPT);
            if (in_if.option == ON_OPT) begin
              phase_nxt = settle_ph;
              timer_nxt = SETTLE_T;
            end
          end else if (in_if.req_type == REQ_LIGHT) begin
            light_nxt = (in_if.option == ON_OPT);
          end else if ({1'b0, in_if.option} >= (OPT_W+1)'(NUM_STATES)) begin
            status_nxt = ST_INVALID;
          end else if (opt_st == ind_r) begin
            status_nxt = ST_SAME;
          end else begin
            pulses_nxt = diff;
            phase_nxt  = PH_PULSE;
            timer_nxt  = width_r;
          end
        end
        default: status_nxt = ST_UNKNOWN;
      endcase
    end

    res_nxt.status      = status_nxt;
    res_nxt.trigger_pin = (phase_nxt == PH_PULSE) ^ trig_inv_r;
    res_nxt.power_pin   = power_nxt ^ power_inv_r;
    res_nxt.light_pin   = light_nxt ^ light_inv_r;
    res_nxt.lamp_state  = ind_nxt;
    res_nxt.busy_res    = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ind_r    <= '0;
      pulses_r <= '0;
      phase_r  <= settle_ph;
      timer_r  <= SETTLE_T;
      power_r  <= 1'b1;
      light_r  <= 1'b0;
    end else begin
      ind_r    <= ind_nxt;
      pulses_r <= pulses_nxt;
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      power_r  <= power_nxt;
      light_r  <= light_nxt;
    end
  end

  // result buffer: head plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          head_v_r <= push;
        end
      end else if (push) begin
        if (head_v_r) begin
          skid_v_r <= 1'b1;
        end else begin
          head_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_v_r) begin
      head_r <= skid_r;
    end else if (push && (pop || !head_v_r)) begin
      head_r <= res_nxt;
    end
    if (push && head_v_r && !pop) begin
      skid_r <= res_nxt;
    end
  end

  assign out_if.valid       = head_v_r;
  assign out_if.status      = head_r.status;
  assign out_if.trigger_pin = head_r.trigger_pin;
  assign out_if.power_pin   = head_r.power_pin;
  assign out_if.light_pin   = head_r.light_pin;
  assign out_if.lamp_state  = head_r.lamp_state;
  assign out_if.busy_res    = head_r.busy_res;

  `ASSERT_IMPLIES(a_skid_needs_head, clk, rst_n, skid_v_r, head_v_r,
                  "skid entry held without a head entry")
  `ASSERT_ALWAYS(a_pulses_match_phase, clk, rst_n,
                 ((phase_r == PH_PULSE) || (phase_r == PH_GAP)) == (pulses_r != '0),
                 "pulse count disagrees with phase")
  `ASSERT_ALWAYS(a_state_in_range, clk, rst_n, ind_r <= LAST_ST,
                 "indicator state out of range")
  `ASSERT_NEXT(a_state_cmd_starts_pulse, clk, rst_n,
               push && (in_if.req_type == REQ_STATE) && (status_nxt == ST_OK),
               phase_r == PH_PULSE,
               "accepted set-state did not start a pulse")

endmodule

`default_nettype wire
